// ----- sv/kar_pkg.sv -----
// shared constants, types and helpers for the key auto-repeat event queue
`default_nettype none

package kar_pkg;

    // sizing
    localparam int NUM_KEYS    = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int Q_IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int EVT_KEY_W  = 3;
    localparam int EVT_TYPE_W = 2;
    localparam int MODE_W     = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((LEVEL_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((EVT_KEY_W + EVT_TYPE_W + 7) / 8) * 8;

    // register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_PRESS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_DELAY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT     = 2'd2;

    localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd100;
    localparam logic [CFG_W-1:0] HOLD_DELAY_RST = 16'd300;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd100;

    // beat kinds on the input channel
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // key modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLICK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;

    // event types
    localparam logic [EVT_TYPE_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVT_TYPE_W-1:0] EVT_CLICK = 2'd1;
    localparam logic [EVT_TYPE_W-1:0] EVT_HOLD  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] min_press_ms;
        logic [CFG_W-1:0] hold_delay_ms;
        logic [CFG_W-1:0] repeat_ms;
    } cfg_t;

    // what one lane found on the last scan
    typedef struct packed {
        logic                  valid;
        logic [EVT_TYPE_W-1:0] etype;
    } lane_event_t;

    // merge stage to queue
    typedef struct packed {
        logic                  valid;
        logic [EVT_KEY_W-1:0]  key;
        logic [EVT_TYPE_W-1:0] etype;
    } push_t;

    typedef struct packed {
        logic [EVT_KEY_W-1:0]  key;
        logic [EVT_TYPE_W-1:0] etype;
    } entry_t;

    // low bits of a key index as the event key field
    function automatic logic [EVT_KEY_W-1:0] key_field(input logic [KEY_IDX_W-1:0] idx);
        logic [EVT_KEY_W+KEY_IDX_W-1:0] wide;
        wide = {{EVT_KEY_W{1'b0}}, idx};
        return wide[EVT_KEY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/kar_key_lane.sv -----
// one key lane: mode and time stamp of a single key, updated on every scan
`default_nettype none

module kar_key_lane (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           scan_en,
    input  wire                           pressed,
    input  wire [kar_pkg::TIME_W-1:0]     now_ms,
    input  kar_pkg::cfg_t                 cfg,
    output kar_pkg::lane_event_t          ev
);

    logic [kar_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [kar_pkg::TIME_W-1:0] stamp_reg, stamp_next;
    kar_pkg::lane_event_t       ev_reg, ev_next;

    logic [kar_pkg::TIME_W-1:0] elapsed;
    logic [kar_pkg::CFG_W-1:0]  threshold;
    logic                       expired;

    // elapsed time against the limit that applies in this mode
    always_comb begin
        elapsed = now_ms - stamp_reg;
        if (!pressed) begin
            threshold = cfg.min_press_ms;
        end else if (mode_reg == kar_pkg::MODE_CLICK) begin
            threshold = cfg.hold_delay_ms;
        end else begin
            threshold = cfg.repeat_ms;
        end
        expired = elapsed >= {{(kar_pkg::TIME_W - kar_pkg::CFG_W){1'b0}}, threshold};
    end

    // per-key mode transitions
    always_comb begin
        mode_next  = mode_reg;
        stamp_next = stamp_reg;
        ev_next    = ev_reg;
        if (scan_en) begin
            ev_next = '0;
            if (!pressed) begin
                if (mode_reg != kar_pkg::MODE_IDLE && expired) begin
                    mode_next  = kar_pkg::MODE_IDLE;
                    stamp_next = '0;
                end
            end else begin
                case (mode_reg)
                    kar_pkg::MODE_CLICK: begin
                        if (expired) begin
                            mode_next     = kar_pkg::MODE_HOLD;
                            stamp_next    = now_ms;
                            ev_next.valid = 1'b1;
                            ev_next.etype = kar_pkg::EVT_HOLD;
                        end
                    end
                    kar_pkg::MODE_HOLD: begin
                        if (expired) begin
                            stamp_next    = now_ms;
                            ev_next.valid = 1'b1;
                            ev_next.etype = kar_pkg::EVT_HOLD;
                        end
                    end
                    default: begin
                        mode_next     = kar_pkg::MODE_CLICK;
                        stamp_next    = now_ms;
                        ev_next.valid = 1'b1;
                        ev_next.etype = kar_pkg::EVT_CLICK;
                    end
                endcase
            end
        end
    end

    // lane state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= kar_pkg::MODE_IDLE;
            stamp_reg <= '0;
            ev_reg    <= '0;
        end else begin
            mode_reg  <= mode_next;
            stamp_reg <= stamp_next;
            ev_reg    <= ev_next;
        end
    end

    assign ev = ev_reg;

endmodule

`default_nettype wire

// ----- sv/kar_merge.sv -----
// merge stage: walks the lanes in key order and pushes their events one a cycle
`default_nettype none

module kar_merge (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   start,
    input  kar_pkg::lane_event_t  lane_ev [kar_pkg::NUM_KEYS],
    output kar_pkg::push_t        push,
    output logic                  busy
);

    localparam logic [kar_pkg::KEY_IDX_W-1:0] LAST_KEY =
        kar_pkg::KEY_IDX_W'(kar_pkg::NUM_KEYS - 1);

    logic                          active_reg, active_next;
    logic [kar_pkg::KEY_IDX_W-1:0] idx_reg, idx_next;

    // walk control
    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (start) begin
            active_next = 1'b1;
            idx_next    = '0;
        end else if (active_reg) begin
            if (idx_reg == LAST_KEY) begin
                active_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    // event of the current key towards the queue
    always_comb begin
        push.valid = active_reg && lane_ev[idx_reg].valid;
        push.key   = kar_pkg::key_field(idx_reg);
        push.etype = lane_ev[idx_reg].etype;
    end

    assign busy = active_reg;

endmodule

`default_nettype wire

// ----- sv/kar_event_queue.sv -----
// ring fifo of events: drops pushes when full, registered read on pop
`default_nettype none

module kar_event_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  kar_pkg::push_t       push,
    input  wire                  pop,
    output kar_pkg::entry_t      rd_entry,
    output logic                 rd_empty
);

    localparam logic [kar_pkg::Q_IDX_W-1:0] LAST_SLOT =
        kar_pkg::Q_IDX_W'(kar_pkg::QUEUE_DEPTH - 1);
    localparam logic [kar_pkg::Q_IDX_W:0]   DEPTH_EXT =
        (kar_pkg::Q_IDX_W + 1)'(kar_pkg::QUEUE_DEPTH);
    localparam logic [kar_pkg::Q_CNT_W-1:0] DEPTH_CNT =
        kar_pkg::Q_CNT_W'(kar_pkg::QUEUE_DEPTH);

    kar_pkg::entry_t store_mem [kar_pkg::QUEUE_DEPTH];

    logic [kar_pkg::Q_IDX_W-1:0] head_reg, head_next;
    logic [kar_pkg::Q_CNT_W-1:0] count_reg, count_next;
    kar_pkg::entry_t             rd_entry_reg;
    logic                        rd_empty_reg;

    logic                        full;
    logic                        push_ok;
    logic                        pop_ok;
    logic [kar_pkg::Q_IDX_W:0]   tail_sum;
    logic [kar_pkg::Q_IDX_W:0]   tail_wrap;
    logic [kar_pkg::Q_IDX_W-1:0] tail;

    // write slot: head plus count, wrapped once
    always_comb begin
        full      = count_reg == DEPTH_CNT;
        push_ok   = push.valid && !full;
        pop_ok    = pop && (count_reg != '0);
        tail_sum  = (kar_pkg::Q_IDX_W + 1)'(head_reg) + (kar_pkg::Q_IDX_W + 1)'(count_reg);
        tail_wrap = (tail_sum >= DEPTH_EXT) ? (tail_sum - DEPTH_EXT) : tail_sum;
        tail      = tail_wrap[kar_pkg::Q_IDX_W-1:0];
    end

    // head and fill count
    always_comb begin
        head_next = head_reg;
        if (pop_ok) begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            rd_empty_reg <= 1'b1;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (pop) begin
                rd_empty_reg <= count_reg == '0;
            end
        end
    end

    // event store write
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            store_mem[tail] <= '{key: push.key, etype: push.etype};
        end
    end

    // event store read
    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_entry_reg <= store_mem[head_reg];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_empty = rd_empty_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("event queue count above depth");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && full && !pop) |=> $stable(count_reg) && $stable(head_reg))
        else $error("push into full queue changed its state");

    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && pop))
        else $error("push and pop in the same cycle");
`endif

endmodule

`default_nettype wire

// ----- sv/key_auto_repeat_event_queue_top.sv -----
// top level: register port, item sequencing, key lanes, merge stage, queue, output register
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser: kind; s_tdata: key_levels, now_ms
//  m_        out  m_tvalid/m_tready  m_tdata: event_key, event_type
//  apb       in   psel/penable       paddr, pwdata, prdata (pready tied high)
//
//  a scan beat: all lanes update at the accept edge,
//  the merge stage pushes one key's event per cycle, then the sequencer returns to idle
//  a pop beat does the registered fifo read, then loads m_
//  a pop waits while a previous result sits unaccepted in the output register
//  reset (aresetn low, synchronous) puts all keys idle and empties the queue
`default_nettype none

module key_auto_repeat_event_queue_top (
    input  wire                                aclk,
    input  wire                                aresetn,
    // input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [kar_pkg::S_TDATA_W-1:0]       s_tdata,   // key_levels[7:0], now_ms[39:8]
    input  wire                                s_tuser,   // kind[0]
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [kar_pkg::M_TDATA_W-1:0]      m_tdata,   // event_key[2:0], event_type[4:3]
    // register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [kar_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [kar_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kar_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0] state_reg, state_next;

    kar_pkg::cfg_t cfg_reg, cfg_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [kar_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                          in_accept;
    logic                          scan_start;
    logic                          pop_start;
    logic                          out_load;
    logic [kar_pkg::LEVEL_W-1:0]   key_levels;
    logic [kar_pkg::TIME_W-1:0]    now_ms;
    logic [kar_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_wr;

    kar_pkg::lane_event_t lane_ev [kar_pkg::NUM_KEYS];
    kar_pkg::push_t       push;
    logic                 merge_busy;
    kar_pkg::entry_t      rd_entry;
    logic                 rd_empty;

    // input beat decode
    assign s_tready   = state_reg == ST_IDLE;
    assign in_accept  = s_tvalid && s_tready;
    assign scan_start = in_accept && (s_tuser == kar_pkg::KIND_SCAN);
    assign pop_start  = in_accept && (s_tuser == kar_pkg::KIND_POP);
    assign key_levels = s_tdata[kar_pkg::LEVEL_W-1:0];
    assign now_ms     = s_tdata[kar_pkg::LEVEL_W+kar_pkg::TIME_W-1:kar_pkg::LEVEL_W];

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[kar_pkg::REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                kar_pkg::REG_MIN_PRESS:  cfg_next.min_press_ms  = pwdata[kar_pkg::CFG_W-1:0];
                kar_pkg::REG_HOLD_DELAY: cfg_next.hold_delay_ms = pwdata[kar_pkg::CFG_W-1:0];
                kar_pkg::REG_REPEAT:     cfg_next.repeat_ms     = pwdata[kar_pkg::CFG_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            kar_pkg::REG_MIN_PRESS:
                prdata = kar_pkg::APB_DATA_W'(cfg_reg.min_press_ms);
            kar_pkg::REG_HOLD_DELAY:
                prdata = kar_pkg::APB_DATA_W'(cfg_reg.hold_delay_ms);
            kar_pkg::REG_REPEAT:
                prdata = kar_pkg::APB_DATA_W'(cfg_reg.repeat_ms);
            default:
                prdata = '0;
        endcase
    end

    // key lanes, keys past the level field read as released
    for (genvar k = 0; k < kar_pkg::NUM_KEYS; k++) begin : g_lane
        logic pressed;
        if (k < kar_pkg::LEVEL_W) begin : g_level
            assign pressed = key_levels[k];
        end else begin : g_none
            assign pressed = 1'b0;
        end
        kar_key_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .scan_en (scan_start),
            .pressed (pressed),
            .now_ms  (now_ms),
            .cfg     (cfg_reg),
            .ev      (lane_ev[k])
        );
    end

    kar_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .lane_ev (lane_ev),
        .push    (push),
        .busy    (merge_busy)
    );

    kar_event_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop_start),
        .rd_entry (rd_entry),
        .rd_empty (rd_empty)
    );

    // item sequencing
    assign out_load = (state_reg == ST_POP) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (scan_start) begin
                    state_next = ST_SCAN;
                end else if (pop_start) begin
                    state_next = ST_POP;
                end
            end
            ST_SCAN: begin
                if (!merge_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            if (rd_empty) begin
                m_tdata_next = kar_pkg::M_TDATA_W'({kar_pkg::EVT_NONE,
                                                    {kar_pkg::EVT_KEY_W{1'b0}}});
            end else begin
                m_tdata_next = kar_pkg::M_TDATA_W'({rd_entry.etype, rd_entry.key});
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            m_tvalid_reg         <= 1'b0;
            cfg_reg.min_press_ms  <= kar_pkg::MIN_PRESS_RST;
            cfg_reg.hold_delay_ms <= kar_pkg::HOLD_DELAY_RST;
            cfg_reg.repeat_ms     <= kar_pkg::REPEAT_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !merge_busy) |=> (state_reg == ST_IDLE))
        else $error("scan did not return to idle after the merge finished");
`endif

endmodule

`default_nettype wire
